// ===== rtl/crank_sync_handover_controller_defines.svh =====
// assertion macros for the rtl control unit (csh_ctrl)
`ifndef CRANK_SYNC_HANDOVER_CONTROLLER_DEFINES_SVH
`define CRANK_SYNC_HANDOVER_CONTROLLER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define CSH_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define CSH_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CSH_ASSERT_SAME(name, ante, cons, msg)
`define CSH_ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

// ===== rtl/csh_pkg.sv =====
package csh_pkg;

  typedef enum logic [2:0] {
    CMD_START    = 3'd0,
    CMD_STOP     = 3'd1,
    CMD_SYNC     = 3'd2,
    CMD_HANDOVER = 3'd3,
    CMD_TIMEOUT  = 3'd4,
    CMD_CLEAR    = 3'd5,
    CMD_READ     = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_INVALID = 2'd1,
    STAT_TIMEOUT = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    REG_PRIME_PULSES = 3'd0,
    REG_PRIME_VOLT   = 3'd1,
    REG_ADVANCE      = 3'd2,
    REG_ENRICH       = 3'd3,
    REG_TIMEOUT      = 3'd4
  } cfg_reg_t;

  localparam int NUM_W = 26;
  localparam logic [NUM_W-1:0] RPM_NUM = 26'd60000000;
  localparam logic [NUM_W-1:0] RPM_MAX = 26'd15000;
  localparam logic [19:0] PRIME_BASE  = 20'd2000;
  localparam logic [19:0] PRIME_SCALE = 20'd10;

  typedef struct packed {
    logic load;
    logic mul_en;
    logic div_start;
    logic commit;
  } ctl_t;

  typedef struct packed {
    logic div_done;
  } stat_t;

endpackage

// ===== rtl/crank_sync_handover_controller.sv =====
// channel | direction | handshake           | beat
// in      | in        | in_valid/in_ready   | cmd, tooth_period, gap_flag, phase_flag, now_ms
// out     | out       | out_valid/out_ready | status, speed_rpm ... enrichment_out
// cfg     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
// a non-sync command goes from accept straight to the commit state; a sync event first passes the multiply
// and divider-start states and the 26-step bit-serial rpm divider, then the commit state
// one item in flight; the next beat is taken while a result still waits in the output register
// rst is synchronous and clears state, config and divider flags, not the latched item or outputs
// cfg is always ready; a stalled out channel holds the finished item before commit
module crank_sync_handover_controller #(
  parameter int TEETH_PER_REV = 60,
  parameter int SYNC_TEETH    = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  cmd,
  input  logic [31:0] tooth_period,
  input  logic        gap_flag,
  input  logic        phase_flag,
  input  logic [31:0] now_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [13:0] speed_rpm,
  output logic [15:0] teeth_since_gap,
  output logic [5:0]  flags,
  output logic [19:0] prime_width_us,
  output logic [7:0]  prime_pulses,
  output logic [15:0] advance_out,
  output logic [15:0] enrichment_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import csh_pkg::*;

  ctl_t  ctl;
  stat_t stat;
  logic  in_is_sync;

  assign cfg_ready  = 1'b1;
  assign in_is_sync = (cmd_t'(cmd) == CMD_SYNC);

  csh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_is_sync(in_is_sync),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .stat      (stat),
    .ctl       (ctl)
  );

  csh_dp #(
    .TEETH_PER_REV(TEETH_PER_REV),
    .SYNC_TEETH   (SYNC_TEETH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .tooth_period   (tooth_period),
    .gap_flag       (gap_flag),
    .phase_flag     (phase_flag),
    .now_ms         (now_ms),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .ctl            (ctl),
    .stat           (stat),
    .status         (status),
    .speed_rpm      (speed_rpm),
    .teeth_since_gap(teeth_since_gap),
    .flags          (flags),
    .prime_width_us (prime_width_us),
    .prime_pulses   (prime_pulses),
    .advance_out    (advance_out),
    .enrichment_out (enrichment_out)
  );

endmodule

// ===== rtl/csh_div.sv =====
module csh_div #(
  parameter int DEN_W = 38
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [DEN_W-1:0]          den,
  output logic                      done,
  output logic [csh_pkg::NUM_W-1:0] quot
);
  import csh_pkg::*;

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] rem;
  logic [NUM_W:0]   trial;
  logic             ge;

  // restoring division of the fixed numerator, one bit a cycle
  assign trial = {rem, RPM_NUM[cnt]};
  assign ge    = (DEN_W'(trial) >= den);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CNT_W'(NUM_W - 1);
      rem  <= '0;
      quot <= '0;
    end else if (busy) begin
      rem  <= ge ? NUM_W'(trial - den[NUM_W:0]) : NUM_W'(trial);
      quot <= {quot[NUM_W-2:0], ge};
      if (cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/csh_dp.sv =====
module csh_dp #(
  parameter int TEETH_PER_REV = 60,
  parameter int SYNC_TEETH    = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [2:0]          cmd,
  input  logic [31:0]         tooth_period,
  input  logic                gap_flag,
  input  logic                phase_flag,
  input  logic [31:0]         now_ms,
  input  logic                cfg_valid,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  csh_pkg::ctl_t       ctl,
  output csh_pkg::stat_t      stat,
  output logic [1:0]          status,
  output logic [13:0]         speed_rpm,
  output logic [15:0]         teeth_since_gap,
  output logic [5:0]          flags,
  output logic [19:0]         prime_width_us,
  output logic [7:0]          prime_pulses,
  output logic [15:0]         advance_out,
  output logic [15:0]         enrichment_out
);
  import csh_pkg::*;

  localparam int TPR_W = $clog2(TEETH_PER_REV + 1);
  localparam int DEN_W = 32 + TPR_W;

  // latched item
  cmd_t        cmd_q;
  logic [31:0] period_q;
  logic        gap_q;
  logic        phase_q;
  logic [31:0] now_q;

  // configuration
  logic [7:0]  prime_count;
  logic [15:0] prime_voltage;
  logic [15:0] crank_advance;
  logic [15:0] crank_enrichment;
  logic [31:0] crank_timeout_ms;

  // live and snapshot state
  logic        cranking, prime_active, sync_acquired, handover_done, gap_seen, phase_seen;
  logic [13:0] live_rpm;
  logic [15:0] tooth_count;
  logic [31:0] start_time_ms;
  logic [13:0] snap_rpm;
  logic [15:0] snap_teeth;
  logic [1:0]  snap_gap_phase;
  logic [15:0] snap_advance;
  logic [15:0] snap_enrichment;

  logic        cranking_next, prime_active_next, sync_next, handover_next;
  logic        gap_seen_next, phase_seen_next;
  logic [13:0] live_rpm_next;
  logic [15:0] tooth_count_next;
  logic [31:0] start_time_next;
  logic        snap_en;
  status_t     status_next;

  logic [DEN_W-1:0] den;
  logic             div_done;
  logic [NUM_W-1:0] div_quot;
  logic [13:0]      rpm_calc;
  logic [15:0]      teeth_inc;
  logic [31:0]      elapsed;

  csh_div #(
    .DEN_W(DEN_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(ctl.div_start),
    .den  (den),
    .done (div_done),
    .quot (div_quot)
  );

  assign stat.div_done = div_done;

  assign rpm_calc  = (div_quot > RPM_MAX) ? 14'd0 : div_quot[13:0];
  assign teeth_inc = (tooth_count != 16'hFFFF) ? tooth_count + 16'd1 : tooth_count;
  assign elapsed   = now_q - start_time_ms;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q    <= cmd_t'(cmd);
      period_q <= tooth_period;
      gap_q    <= gap_flag;
      phase_q  <= phase_flag;
      now_q    <= now_ms;
    end
    if (ctl.mul_en) begin
      den <= DEN_W'(period_q) * DEN_W'(TEETH_PER_REV);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prime_count       <= '0;
      prime_voltage     <= '0;
      crank_advance     <= '0;
      crank_enrichment  <= '0;
      crank_timeout_ms  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PRIME_PULSES: prime_count       <= cfg_data[7:0];
        REG_PRIME_VOLT:   prime_voltage     <= cfg_data[15:0];
        REG_ADVANCE:      crank_advance     <= cfg_data[15:0];
        REG_ENRICH:       crank_enrichment  <= cfg_data[15:0];
        REG_TIMEOUT:      crank_timeout_ms  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cranking_next     = cranking;
    prime_active_next = prime_active;
    sync_next         = sync_acquired;
    handover_next     = handover_done;
    gap_seen_next     = gap_seen;
    phase_seen_next   = phase_seen;
    live_rpm_next     = live_rpm;
    tooth_count_next  = tooth_count;
    start_time_next   = start_time_ms;
    snap_en           = 1'b0;
    status_next       = STAT_OK;
    unique case (cmd_q)
      CMD_START: begin
        if (cranking) begin
          status_next = STAT_INVALID;
        end else begin
          cranking_next     = 1'b1;
          prime_active_next = 1'b1;
          sync_next         = 1'b0;
          handover_next     = 1'b0;
          gap_seen_next     = 1'b0;
          phase_seen_next   = 1'b0;
          live_rpm_next     = '0;
          tooth_count_next  = '0;
          start_time_next   = now_q;
        end
      end
      CMD_STOP, CMD_CLEAR: begin
        if (!cranking && cmd_q == CMD_STOP) begin
          status_next = STAT_INVALID;
        end else begin
          cranking_next     = 1'b0;
          prime_active_next = 1'b0;
          sync_next         = 1'b0;
          handover_next     = 1'b0;
          gap_seen_next     = 1'b0;
          phase_seen_next   = 1'b0;
          live_rpm_next     = '0;
          tooth_count_next  = '0;
          start_time_next   = '0;
        end
      end
      CMD_SYNC: begin
        if (!cranking) begin
          status_next = STAT_INVALID;
        end else begin
          live_rpm_next    = rpm_calc;
          tooth_count_next = gap_q ? 16'd0 : teeth_inc;
          gap_seen_next    = gap_seen | gap_q;
          phase_seen_next  = phase_seen | phase_q;
          if (tooth_count_next >= 16'(SYNC_TEETH) && gap_seen_next && phase_seen_next) begin
            sync_next = 1'b1;
          end
        end
      end
      CMD_HANDOVER: begin
        if (!cranking || !sync_acquired) begin
          status_next = STAT_INVALID;
        end else begin
          snap_en       = 1'b1;
          cranking_next = 1'b0;
          handover_next = 1'b1;
        end
      end
      CMD_TIMEOUT: begin
        if (!cranking) begin
          status_next = STAT_INVALID;
        end else if (elapsed > crank_timeout_ms) begin
          status_next = STAT_TIMEOUT;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cranking        <= 1'b0;
      prime_active    <= 1'b0;
      sync_acquired   <= 1'b0;
      handover_done   <= 1'b0;
      gap_seen        <= 1'b0;
      phase_seen      <= 1'b0;
      live_rpm        <= '0;
      tooth_count     <= '0;
      start_time_ms   <= '0;
      snap_rpm        <= '0;
      snap_teeth      <= '0;
      snap_gap_phase  <= '0;
      snap_advance    <= '0;
      snap_enrichment <= '0;
    end else if (ctl.commit) begin
      cranking      <= cranking_next;
      prime_active  <= prime_active_next;
      sync_acquired <= sync_next;
      handover_done <= handover_next;
      gap_seen      <= gap_seen_next;
      phase_seen    <= phase_seen_next;
      live_rpm      <= live_rpm_next;
      tooth_count   <= tooth_count_next;
      start_time_ms <= start_time_next;
      if (snap_en) begin
        snap_rpm        <= live_rpm;
        snap_teeth      <= tooth_count;
        snap_gap_phase  <= {phase_seen, gap_seen};
        snap_advance    <= crank_advance;
        snap_enrichment <= crank_enrichment;
      end
    end
  end

  // output register, loaded from the state as it stands after the command
  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      status         <= status_next;
      prime_width_us <= PRIME_BASE + 20'(prime_voltage) * PRIME_SCALE;
      prime_pulses   <= prime_count;
      if (handover_next) begin
        speed_rpm       <= snap_en ? live_rpm : snap_rpm;
        teeth_since_gap <= snap_en ? tooth_count : snap_teeth;
        flags           <= {(snap_en ? {phase_seen, gap_seen} : snap_gap_phase),
                            handover_next, sync_next, prime_active_next, cranking_next};
        advance_out     <= snap_en ? crank_advance : snap_advance;
        enrichment_out  <= snap_en ? crank_enrichment : snap_enrichment;
      end else begin
        speed_rpm       <= live_rpm_next;
        teeth_since_gap <= tooth_count_next;
        flags           <= {phase_seen_next, gap_seen_next, handover_next, sync_next,
                            prime_active_next, cranking_next};
        advance_out     <= crank_advance;
        enrichment_out  <= crank_enrichment;
      end
    end
  end

endmodule

// ===== rtl/csh_ctrl.sv =====
`include "crank_sync_handover_controller_defines.svh"

module csh_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_is_sync,
  output logic           in_ready,
  input  logic           out_ready,
  output logic           out_valid,
  input  csh_pkg::stat_t stat,
  output csh_pkg::ctl_t  ctl
);
  import csh_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DSTART,
    S_DIV,
    S_COMMIT
  } state_t;

  state_t state;
  logic   accept;
  logic   out_free;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  assign ctl.load      = accept;
  assign ctl.mul_en    = (state == S_MUL);
  assign ctl.div_start = (state == S_DSTART);
  assign ctl.commit    = (state == S_COMMIT) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (ctl.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= in_is_sync ? S_MUL : S_COMMIT;
          end
        end
        S_MUL:    state <= S_DSTART;
        S_DSTART: state <= S_DIV;
        S_DIV: begin
          if (stat.div_done) begin
            state <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `CSH_ASSERT_SAME(a_commit_room, ctl.commit, !out_valid || out_ready, "result overwritten")
  `CSH_ASSERT_NEXT(a_commit_shows, ctl.commit, out_valid, "committed result not shown")
  `CSH_ASSERT_NEXT(a_sync_to_mul, accept && in_is_sync, state == S_MUL, "sync skipped speed")
  `CSH_ASSERT_NEXT(a_div_to_commit, state == S_DIV && stat.div_done, state == S_COMMIT,
                   "divider finish lost")

endmodule

// ===== verif/crank_sync_handover_controller_tb.sv =====
`timescale 1ns / 100ps

module crank_sync_handover_controller_tb;
  import csh_pkg::*;

  localparam int TEETH_PER_REV = 60;
  localparam int SYNC_TEETH = 10;
  localparam logic [2:0] CMD_SPARE = 3'd7;
  localparam logic [2:0] REG_SPARE = 3'd7;
  localparam int RANDOM_BEATS = 1000;

  typedef struct {
    logic [1:0]  status;
    logic [13:0] rpm;
    logic [15:0] teeth;
    logic [5:0]  flags;
    logic [19:0] prime_width;
    logic [7:0]  pulses;
    logic [15:0] advance;
    logic [15:0] enrich;
  } crank_result_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  cmd;
  logic [31:0] tooth_period;
  logic        gap_flag;
  logic        phase_flag;
  logic [31:0] now_ms;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  status;
  logic [13:0] speed_rpm;
  logic [15:0] teeth_since_gap;
  logic [5:0]  flags;
  logic [19:0] prime_width_us;
  logic [7:0]  prime_pulses;
  logic [15:0] advance_out;
  logic [15:0] enrichment_out;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  crank_sync_handover_controller uut (.*);

  // predicted controller state
  logic [7:0]  cfg_pulses;
  logic [15:0] cfg_volt;
  logic [15:0] cfg_adv;
  logic [15:0] cfg_enr;
  logic [31:0] cfg_tmo;
  logic        crk_on, prime_on, synced, handed_over, gap_latched, phase_latched;
  logic [13:0] rpm_live;
  logic [15:0] teeth_live;
  logic [31:0] t_start;
  logic [13:0] held_rpm;
  logic [15:0] held_teeth;
  logic [1:0]  held_gap_phase;
  logic [15:0] held_advance;
  logic [15:0] held_enrich;

  crank_result_t expected_q[$];
  int mismatches = 0;
  int beats_sent = 0;
  bit steady = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #60_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [13:0] rpm_from_period(logic [31:0] period);
    logic [63:0] den;
    logic [63:0] q;
    den = {32'b0, period} * 64'(TEETH_PER_REV);
    if (den == 0) return '0;
    q = 64'd60000000 / den;
    if (q > 64'd15000) return '0;
    return q[13:0];
  endfunction

  function automatic void clear_run();
    crk_on = 0;
    prime_on = 0;
    synced = 0;
    handed_over = 0;
    rpm_live = '0;
    teeth_live = '0;
    gap_latched = 0;
    phase_latched = 0;
    t_start = '0;
  endfunction

  function automatic crank_result_t crank_step(logic [2:0] op, logic [31:0] period, logic g,
                                               logic ph, logic [31:0] now);
    crank_result_t r;
    logic [31:0] elapsed;
    r.status = STAT_OK;
    case (op)
      CMD_START: begin
        if (crk_on) begin
          r.status = STAT_INVALID;
        end else begin
          clear_run();
          crk_on = 1;
          prime_on = 1;
          t_start = now;
        end
      end
      CMD_STOP: begin
        if (!crk_on) r.status = STAT_INVALID;
        else clear_run();
      end
      CMD_SYNC: begin
        if (!crk_on) begin
          r.status = STAT_INVALID;
        end else begin
          rpm_live = rpm_from_period(period);
          if (teeth_live != 16'hFFFF) teeth_live = teeth_live + 1'b1;
          if (g) begin
            gap_latched = 1;
            teeth_live = '0;
          end
          if (ph) phase_latched = 1;
          if (teeth_live >= SYNC_TEETH && gap_latched && phase_latched) synced = 1;
        end
      end
      CMD_HANDOVER: begin
        if (!crk_on || !synced) begin
          r.status = STAT_INVALID;
        end else begin
          held_rpm = rpm_live;
          held_teeth = teeth_live;
          held_gap_phase = {phase_latched, gap_latched};
          held_advance = cfg_adv;
          held_enrich = cfg_enr;
          crk_on = 0;
          handed_over = 1;
        end
      end
      CMD_TIMEOUT: begin
        elapsed = now - t_start;
        if (!crk_on) r.status = STAT_INVALID;
        else if (elapsed > cfg_tmo) r.status = STAT_TIMEOUT;
      end
      CMD_CLEAR: clear_run();
      default: ;
    endcase
    r.rpm = handed_over ? held_rpm : rpm_live;
    r.teeth = handed_over ? held_teeth : teeth_live;
    r.flags[3:0] = {handed_over, synced, prime_on, crk_on};
    r.flags[5:4] = handed_over ? held_gap_phase : {phase_latched, gap_latched};
    r.prime_width = 20'd2000 + {4'b0, cfg_volt} * 20'd10;
    r.pulses = cfg_pulses;
    r.advance = handed_over ? held_advance : cfg_adv;
    r.enrich = handed_over ? held_enrich : cfg_enr;
    return r;
  endfunction

  task automatic cmp_field(string what, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      mismatches++;
      $display("%0t: %s expected %0h actual %0h", $time, what, want_v, got_v);
    end
  endtask

  // result beats, checked in order against the predictions
  always @(posedge clk) begin
    crank_result_t want, got;
    if (!rst && out_valid && out_ready) begin
      got = '{status, speed_rpm, teeth_since_gap, flags, prime_width_us, prime_pulses,
              advance_out, enrichment_out};
      if (expected_q.size() == 0) begin
        mismatches++;
        $display("%0t: result beat expected none, actual status %0h", $time, status);
      end else begin
        want = expected_q.pop_front();
        cmp_field("status", 32'(want.status), 32'(got.status));
        cmp_field("speed_rpm", 32'(want.rpm), 32'(got.rpm));
        cmp_field("teeth_since_gap", 32'(want.teeth), 32'(got.teeth));
        cmp_field("flags", 32'(want.flags), 32'(got.flags));
        cmp_field("prime_width_us", 32'(want.prime_width), 32'(got.prime_width));
        cmp_field("prime_pulses", 32'(want.pulses), 32'(got.pulses));
        cmp_field("advance_out", 32'(want.advance), 32'(got.advance));
        cmp_field("enrichment_out", 32'(want.enrich), 32'(got.enrich));
      end
    end
  end

  always @(negedge clk) begin
    out_ready = steady || ($urandom_range(99) >= 27);
  end

  // leaves in_valid high after the beat is taken; the next caller decides
  task automatic send_beat(logic [2:0] op, logic [31:0] period, logic g, logic ph,
                           logic [31:0] now);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 27) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_valid = 1;
    cmd = op;
    tooth_period = period;
    gap_flag = g;
    phase_flag = ph;
    now_ms = now;
    do @(posedge clk); while (!in_ready);
    expected_q.push_back(crank_step(op, period, g, ph, now));
    beats_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 0;
    while (expected_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    wait_drained();
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_PRIME_PULSES: cfg_pulses = data[7:0];
      REG_PRIME_VOLT:   cfg_volt = data[15:0];
      REG_ADVANCE:      cfg_adv = data[15:0];
      REG_ENRICH:       cfg_enr = data[15:0];
      REG_TIMEOUT:      cfg_tmo = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic load_settings(logic [31:0] pulses, logic [31:0] volt, logic [31:0] adv,
                               logic [31:0] enr, logic [31:0] tmo);
    write_reg(REG_PRIME_PULSES, pulses);
    write_reg(REG_PRIME_VOLT, volt);
    write_reg(REG_ADVANCE, adv);
    write_reg(REG_ENRICH, enr);
    write_reg(REG_TIMEOUT, tmo);
  endtask

  function automatic logic [31:0] rand_period();
    case ($urandom_range(9))
      0: return '0;
      1: return $urandom_range(1, 66);
      2: return $urandom;
      default: return $urandom_range(67, 200000);
    endcase
  endfunction

  // mostly close to the cranking start so the timeout compare goes both ways
  function automatic logic [31:0] rand_now();
    if ($urandom_range(3) == 0) return $urandom;
    return t_start + $urandom_range(0, 3000);
  endfunction

  task automatic test_register_writes();
    load_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(CMD_READ, '0, 0, 0, '0);
    send_beat(CMD_START, '0, 0, 0, 32'h1234_5678);
    send_beat(CMD_TIMEOUT, '0, 0, 0, 32'h1234_5677);
    send_beat(CMD_CLEAR, '0, 0, 0, '0);
    write_reg(REG_SPARE, $urandom);
    send_beat(CMD_READ, '0, 0, 0, '0);
    load_settings(32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    send_beat(CMD_READ, '0, 0, 0, '0);
    send_beat(CMD_START, '0, 0, 0, 32'hFFFF_FFFF);
    send_beat(CMD_TIMEOUT, '0, 0, 0, 32'hFFFF_FFFF);
    send_beat(CMD_TIMEOUT, '0, 0, 0, 32'h0);
    send_beat(CMD_CLEAR, '0, 0, 0, '0);
  endtask

  task automatic test_command_sequence();
    load_settings($urandom, $urandom, $urandom, $urandom, 32'd20);
    send_beat(CMD_READ, 32'hFFFF_FFFF, 1, 1, 32'hFFFF_FFFF);
    send_beat(CMD_SPARE, '0, 0, 0, '0);
    // stop, sync, handover and timeout are all refused while idle
    send_beat(CMD_STOP, '0, 0, 0, '0);
    send_beat(CMD_SYNC, 32'd1000, 1, 1, '0);
    send_beat(CMD_HANDOVER, '0, 0, 0, '0);
    send_beat(CMD_TIMEOUT, '0, 0, 0, 32'hFFFF_FFFF);
    send_beat(CMD_START, '0, 0, 0, 32'hFFFF_FFF0);
    send_beat(CMD_START, '0, 0, 0, 32'h0);
    send_beat(CMD_HANDOVER, '0, 0, 0, '0);
    send_beat(CMD_SYNC, 32'd0, 0, 0, '0);
    send_beat(CMD_SYNC, 32'hFFFF_FFFF, 1, 0, '0);
    send_beat(CMD_SYNC, 32'd66, 0, 1, '0);
    send_beat(CMD_SYNC, 32'd67, 0, 0, '0);
    send_beat(CMD_SYNC, 32'd1, 0, 0, '0);
    // elapsed time wraps through zero, exactly at and just past the limit
    send_beat(CMD_TIMEOUT, '0, 0, 0, 32'h0000_0004);
    send_beat(CMD_TIMEOUT, '0, 0, 0, 32'h0000_0005);
    repeat (7) send_beat(CMD_SYNC, 32'd1000, 0, 0, '0);
    send_beat(CMD_HANDOVER, '0, 0, 0, '0);
    send_beat(CMD_READ, '0, 0, 0, '0);
    send_beat(CMD_SYNC, 32'd500, 1, 1, '0);
    send_beat(CMD_START, '0, 0, 0, 32'd100);
    send_beat(CMD_CLEAR, '0, 0, 0, '0);
    send_beat(CMD_STOP, '0, 0, 0, '0);
  endtask

  task automatic test_long_tooth_run();
    steady = 1;
    send_beat(CMD_CLEAR, '0, 0, 0, '0);
    send_beat(CMD_START, '0, 0, 0, $urandom);
    send_beat(CMD_SYNC, rand_period(), 1, 1, '0);
    repeat (150) send_beat(CMD_SYNC, rand_period(), 0, 0, '0);
    send_beat(CMD_HANDOVER, '0, 0, 0, '0);
    send_beat(CMD_READ, '0, 0, 0, '0);
    steady = 0;
  endtask

  task automatic crank_cycle();
    int lead, run, phase_at, ending;
    send_beat(CMD_START, rand_period(), 1'($urandom_range(1)), 1'($urandom_range(1)),
              $urandom);
    lead = $urandom_range(0, 3);
    repeat (lead) send_beat(CMD_SYNC, rand_period(), 0, $urandom_range(3) == 0, rand_now());
    send_beat(CMD_SYNC, rand_period(), 1, $urandom_range(3) == 0, rand_now());
    run = $urandom_range(6, 16);
    phase_at = $urandom_range(0, run);
    for (int i = 0; i < run; i++) begin
      if ($urandom_range(5) == 0)
        send_beat(CMD_TIMEOUT, $urandom, 1'($urandom_range(1)), 1'($urandom_range(1)),
                  rand_now());
      send_beat(CMD_SYNC, rand_period(), $urandom_range(24) == 0,
                i == phase_at || $urandom_range(9) == 0, rand_now());
    end
    ending = $urandom_range(19);
    if (ending < 12) begin
      send_beat(CMD_HANDOVER, $urandom, 1'($urandom_range(1)), 1'($urandom_range(1)),
                rand_now());
      send_beat(CMD_READ, $urandom, 1'($urandom_range(1)), 1'($urandom_range(1)), $urandom);
      if (ending < 4)
        send_beat(CMD_SYNC, rand_period(), 1'($urandom_range(1)), 1'($urandom_range(1)),
                  rand_now());
    end else if (ending < 15) begin
      send_beat(CMD_STOP, $urandom, 1'($urandom_range(1)), 1'($urandom_range(1)), rand_now());
    end else if (ending < 18) begin
      send_beat(CMD_CLEAR, $urandom, 1'($urandom_range(1)), 1'($urandom_range(1)),
                rand_now());
    end else begin
      send_beat(CMD_START, $urandom, 1'($urandom_range(1)), 1'($urandom_range(1)), $urandom);
      send_beat(CMD_HANDOVER, $urandom, 1'($urandom_range(1)), 1'($urandom_range(1)),
                rand_now());
    end
  endtask

  task automatic test_random_cranking();
    int target, quiet_until;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: load_settings(32'hFF, 32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF_FFFF);
        1: load_settings(32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        2: load_settings($urandom, $urandom, $urandom, $urandom, $urandom_range(0, 2000));
        default: load_settings($urandom, $urandom, $urandom, $urandom, $urandom);
      endcase
      target = beats_sent + RANDOM_BEATS / 4;
      quiet_until = beats_sent + RANDOM_BEATS / 8;
      // one long stretch without any idling on either side
      steady = (ph == 2);
      while (beats_sent < target) begin
        if (steady && beats_sent >= quiet_until) steady = 0;
        if ($urandom_range(99) < 75) begin
          crank_cycle();
        end else begin
          repeat ($urandom_range(1, 4))
            send_beat(3'($urandom_range(7)), rand_period(), 1'($urandom_range(1)),
                      1'($urandom_range(1)), rand_now());
        end
        if ($urandom_range(7) == 0) wait_drained();
      end
      steady = 0;
    end
  endtask

  initial begin
    rst = 1;
    in_valid = 0;
    cmd = CMD_READ;
    tooth_period = '0;
    gap_flag = 0;
    phase_flag = 0;
    now_ms = '0;
    out_ready = 0;
    cfg_valid = 0;
    cfg_index = REG_PRIME_PULSES;
    cfg_data = '0;
    cfg_pulses = '0;
    cfg_volt = '0;
    cfg_adv = '0;
    cfg_enr = '0;
    cfg_tmo = '0;
    clear_run();
    held_rpm = '0;
    held_teeth = '0;
    held_gap_phase = '0;
    held_advance = '0;
    held_enrich = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;

    test_command_sequence();
    test_register_writes();
    test_long_tooth_run();
    test_random_cranking();

    wait_drained();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
